// ===== rtl/core/dtlv_pkg.sv =====
package dtlv_pkg;

	// Longest long-form length field, in bytes after the 0x8n byte
	localparam int LEN_BYTES_MAX = 4;
	localparam int LEN_CNT_W     = $clog2(LEN_BYTES_MAX + 1);

	localparam logic [7:0] TAG_INTEGER = 8'h02;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] BYTE_7F     = 8'h7F;

	// Result queue depth; one item may push two results
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_VAL = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_LEN_LONG = 2'd1,
		ERR_TRUNC    = 2'd2,
		ERR_CAP      = 2'd3
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		logic [31:0] length;
		logic [7:0]  value_byte;
		logic        last;
		err_t        error_code;
	} result_t;

	// Push request into the result queue; slot 1 is used only with slot 0
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} qpush_t;

endpackage

// ===== rtl/core/dtlv_res_queue.sv =====
module dtlv_res_queue
	import dtlv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  qpush_t  push,
	output logic    room2,
	output logic    out_valid,
	output result_t out_res,
	input  logic    out_ready
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic              pop;
	logic [QCNT_W-1:0] n_push;
	logic [QPTR_W-1:0] wr_ptr_p1;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// two free entries, ignoring any pop this cycle
	assign room2     = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign n_push    = QCNT_W'(push.push0) + QCNT_W'(push.push1);
	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_p1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - QCNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/der_tlv_decoder.sv =====
// DER tag-length-value splitter.
// Input stream (s_*): one DER byte per transfer. s_tdata is the byte, s_tlast
// marks the last byte of the supplied buffer, s_tuser selects the mode and is
// sampled on tag bytes only (0 extract value, 1 header only).
// Output stream (m_*): one result per transfer. m_tuser is the kind (header,
// value byte, error); m_tlast marks the final result of an element.
// Config (cfg_*): 32-bit max_value_length, write only while idle; cfg_ready is
// always high. Values longer than this in value mode report over capacity.
// Path: an accepted byte is held in the input register, parsed from there,
// and its results are written into the result queue, which drives m_*.
// Throughput: one byte per clock while the result queue has room. Some bytes
// make two results (such as INTEGER header plus first value byte, or header
// plus error); those leave as two output transfers. Parsing is one pass through
// the parse logic between the input register and a four-entry result queue,
// which takes a byte whenever it has two free entries.
// Reset: parser back to expecting a tag, queue empty, capacity all ones.
// Output stall: the queue fills, then the input register holds and s_tready
// drops; nothing is lost or duplicated.
module der_tlv_decoder
	import dtlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,     // max_value_length
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] data_byte
	input  logic        s_tlast,      // end_of_stream
	input  logic        s_tuser,      // operation
	// results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,      // [7:0] tag, [39:8] length,
	                                  // [47:40] value_byte, [49:48] error_code
	output logic        m_tlast,      // last_of_element
	output logic [1:0]  m_tuser       // kind
);

	typedef enum logic [2:0] {
		PH_TAG    = 3'd0,
		PH_LEN1   = 3'd1,
		PH_LENX   = 3'd2,
		PH_FIRST  = 3'd3,   // first value byte of a long INTEGER
		PH_SECOND = 3'd4,   // second byte after a leading zero
		PH_VALUE  = 3'd5
	} phase_t;

	// input register
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_eos_s1;
	logic       in_op_s1;

	// parser state
	phase_t               phase_q;
	logic [7:0]           tag_q;
	logic [31:0]          acc_q;
	logic [LEN_CNT_W-1:0] len_left_q;
	logic [31:0]          val_left_q;
	logic                 hdr_only_q;
	logic [7:0]           pend_byte_q;
	logic                 pend_valid_q;
	logic [31:0]          max_len_q;

	phase_t               phase_n;
	logic [7:0]           tag_n;
	logic [31:0]          acc_n;
	logic [LEN_CNT_W-1:0] len_left_n;
	logic [31:0]          val_left_n;
	logic                 hdr_only_n;
	logic [7:0]           pend_byte_n;
	logic                 pend_valid_n;

	logic    room2;
	logic    proc;
	qpush_t  qpush;
	result_t out_res;
	result_t res [2];
	logic [1:0] nres;

	assign proc      = in_valid_s1 && room2;
	assign s_tready  = !in_valid_s1 || room2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
			in_eos_s1  <= s_tlast;
			in_op_s1   <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Parse one byte. Results go into res[] in emit order; an error is
	// always the final result of the byte.
	always_comb begin
		logic        do_len;
		logic        do_fail;
		err_t        fcode;
		logic [31:0] left;
		logic [31:0] rep;
		logic        fin;

		phase_n      = phase_q;
		tag_n        = tag_q;
		acc_n        = acc_q;
		len_left_n   = len_left_q;
		val_left_n   = val_left_q;
		hdr_only_n   = hdr_only_q;
		pend_byte_n  = pend_byte_q;
		pend_valid_n = pend_valid_q;
		res[0]       = '0;
		res[1]       = '0;
		nres         = '0;
		do_len       = 1'b0;
		do_fail      = 1'b0;
		fcode        = ERR_NONE;
		left         = '0;
		rep          = '0;
		fin          = 1'b0;

		if (proc) begin
			// held byte of a two-byte INTEGER closes it before the next tag
			if (pend_valid_q && phase_q == PH_TAG) begin
				res[nres[0]] = '{KIND_VAL, tag_n, acc_n, pend_byte_q, 1'b1, ERR_NONE};
				nres = nres + 2'd1;
				pend_valid_n = 1'b0;
			end

			unique case (phase_q)
				PH_TAG: begin
					tag_n      = in_byte_s1;
					hdr_only_n = in_op_s1;
					acc_n      = '0;
					if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						phase_n = PH_LEN1;
					end
				end
				PH_LEN1: begin
					if (!in_byte_s1[7]) begin
						acc_n  = {24'd0, in_byte_s1};
						do_len = 1'b1;
					end else if (in_byte_s1[6:0] > 7'(LEN_BYTES_MAX)) begin
						do_fail = 1'b1;
						fcode   = ERR_LEN_LONG;
					end else if (in_byte_s1[6:0] == 7'd0) begin
						// indefinite form reads as length zero
						acc_n  = '0;
						do_len = 1'b1;
					end else if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						len_left_n = LEN_CNT_W'(in_byte_s1[6:0]);
						phase_n    = PH_LENX;
					end
				end
				PH_LENX: begin
					acc_n = {acc_q[23:0], in_byte_s1};
					if (len_left_q != '0) begin
						len_left_n = len_left_q - LEN_CNT_W'(1);
					end
					if (len_left_n == '0) begin
						do_len = 1'b1;
					end else if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end
				end
				PH_FIRST: begin
					if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						val_left_n = acc_q - 32'd1;
						if (in_byte_s1 == BYTE_ZERO) begin
							phase_n = PH_SECOND;
						end else if (acc_q > max_len_q) begin
							do_fail = 1'b1;
							fcode   = ERR_CAP;
						end else begin
							res[0]  = '{KIND_HDR, tag_n, acc_q, 8'd0, 1'b0, ERR_NONE};
							res[1]  = '{KIND_VAL, tag_n, acc_q, in_byte_s1, 1'b0, ERR_NONE};
							nres    = 2'd2;
							phase_n = PH_VALUE;
						end
					end
				end
				PH_SECOND: begin
					left = val_left_q - 32'd1;
					rep  = acc_q - 32'd1;
					if (left != '0 && in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else if (in_byte_s1 > BYTE_7F) begin
						// leading zero before a byte with the top bit set: drop it
						if (rep > max_len_q) begin
							do_fail = 1'b1;
							fcode   = ERR_CAP;
						end else begin
							acc_n      = rep;
							res[0]     = '{KIND_HDR, tag_n, rep, 8'd0, 1'b0, ERR_NONE};
							res[1]     = '{KIND_VAL, tag_n, rep, in_byte_s1, left == '0,
								ERR_NONE};
							nres       = 2'd2;
							val_left_n = left;
							phase_n    = (left == '0) ? PH_TAG : PH_VALUE;
						end
					end else begin
						// zero kept; this byte is held and goes out with a later byte
						if (acc_q > max_len_q) begin
							do_fail = 1'b1;
							fcode   = ERR_CAP;
						end else begin
							res[0]       = '{KIND_HDR, tag_n, acc_q, 8'd0, 1'b0, ERR_NONE};
							res[1]       = '{KIND_VAL, tag_n, acc_q, BYTE_ZERO, 1'b0, ERR_NONE};
							nres         = 2'd2;
							pend_byte_n  = in_byte_s1;
							pend_valid_n = 1'b1;
							val_left_n   = left;
							phase_n      = (left == '0) ? PH_TAG : PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					left = (val_left_q != '0) ? val_left_q - 32'd1 : '0;
					fin  = (left == '0);
					if (!fin && in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						val_left_n = left;
						if (pend_valid_q) begin
							res[0] = '{KIND_VAL, tag_n, acc_q, pend_byte_q, 1'b0, ERR_NONE};
							if (fin) begin
								res[1] = '{KIND_VAL, tag_n, acc_q, in_byte_s1, 1'b1,
									ERR_NONE};
								nres   = 2'd2;
								pend_valid_n = 1'b0;
							end else begin
								nres        = 2'd1;
								pend_byte_n = in_byte_s1;
							end
						end else begin
							res[0] = '{KIND_VAL, tag_n, acc_q, in_byte_s1, fin, ERR_NONE};
							nres   = 2'd1;
						end
						if (fin) begin
							phase_n = PH_TAG;
						end
					end
				end
				default: begin
					phase_n      = PH_TAG;
					pend_valid_n = 1'b0;
				end
			endcase

			// length field complete
			if (do_len) begin
				if (hdr_only_n) begin
					res[nres[0]] = '{KIND_HDR, tag_n, acc_n, 8'd0, 1'b1, ERR_NONE};
					nres    = nres + 2'd1;
					phase_n = PH_TAG;
				end else if (tag_n == TAG_INTEGER && acc_n >= 32'd2) begin
					// header waits for the first value bytes
					if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						val_left_n = acc_n;
						phase_n    = PH_FIRST;
					end
				end else if (acc_n > max_len_q) begin
					do_fail = 1'b1;
					fcode   = ERR_CAP;
				end else begin
					res[nres[0]] = '{KIND_HDR, tag_n, acc_n, 8'd0, acc_n == '0, ERR_NONE};
					nres = nres + 2'd1;
					if (acc_n == '0) begin
						phase_n = PH_TAG;
					end else if (in_eos_s1) begin
						do_fail = 1'b1;
						fcode   = ERR_TRUNC;
					end else begin
						val_left_n = acc_n;
						phase_n    = PH_VALUE;
					end
				end
			end

			if (do_fail) begin
				res[nres[0]] = '{KIND_ERR, tag_n, 32'd0, 8'd0, 1'b1, fcode};
				nres         = nres + 2'd1;
				phase_n      = PH_TAG;
				pend_valid_n = 1'b0;
				val_left_n   = '0;
				len_left_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TAG;
			tag_q        <= '0;
			acc_q        <= '0;
			len_left_q   <= '0;
			val_left_q   <= '0;
			hdr_only_q   <= 1'b0;
			pend_byte_q  <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			tag_q        <= tag_n;
			acc_q        <= acc_n;
			len_left_q   <= len_left_n;
			val_left_q   <= val_left_n;
			hdr_only_q   <= hdr_only_n;
			pend_byte_q  <= pend_byte_n;
			pend_valid_q <= pend_valid_n;
		end
	end

	assign qpush.push0 = (nres != 2'd0);
	assign qpush.push1 = (nres == 2'd2);
	assign qpush.res0  = res[0];
	assign qpush.res1  = res[1];

	dtlv_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (qpush),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'd0, out_res.error_code, out_res.value_byte, out_res.length,
		out_res.tag};
	assign m_tlast = out_res.last;
	assign m_tuser = out_res.kind;

endmodule
